// ===== rtl/tpt_pkg.sv =====
// ============================================================================
// Touch point tracker package
// Shared types, codes and constants of the touch point tracker core.
// ============================================================================
package tpt_pkg;

    // Reset value of the match radius and of its square.
    localparam logic [9:0]  RADIUS_RESET = 10'd400;
    localparam logic [19:0] LIMIT_RESET  = 20'd160000;

    // An unfound entry whose miss count exceeds this is removed on ageing.
    localparam logic [1:0]  MISS_LIMIT   = 2'd2;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COUNT,
        ST_MOVE
    } t_state;

    // Datapath actions for the current cycle.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_MATCH,
        OP_APPEND,
        OP_DROP,
        OP_REWIND,
        OP_SUMMARY
    } t_op;

    // What a table read is for.
    typedef enum logic [1:0] {
        RD_SCAN,
        RD_COUNT,
        RD_MOVE
    } t_rd;

    // Result kinds as seen on the result port.
    typedef enum logic [2:0] {
        KIND_MATCH   = 3'd0,
        KIND_NEW     = 3'd1,
        KIND_DROPPED = 3'd2,
        KIND_REMOVED = 3'd3,
        KIND_SUMMARY = 3'd4
    } t_kind;

    // One entry of the track table.
    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] ident;
        logic        found;
        logic [1:0]  misses;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        t_op  op;
        logic rd_go;
        t_rd  rd_purpose;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;
        logic scan_busy;
        logic rd_pending;
        logic rd_done;
        logic full;
    } t_dp_stat;

endpackage

// ===== rtl/tpt_ctrl.sv =====
// ============================================================================
// Touch point tracker controller
// Sequences the detection scan and the two ageing passes over the table.
// ============================================================================
module tpt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_command,
    input  tpt_pkg::t_dp_stat i_stat,
    output tpt_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy
);
    import tpt_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = i_command ? ST_COUNT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_stat.hit) begin
                    n_state = ST_IDLE;
                end else if (i_stat.rd_done && !i_stat.scan_busy) begin
                    n_state = ST_IDLE;
                end
            end
            ST_COUNT: begin
                if (i_stat.rd_done && !i_stat.rd_pending) begin
                    n_state = ST_MOVE;
                end
            end
            ST_MOVE: begin
                if (i_stat.rd_done && !i_stat.rd_pending) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd.op         = OP_NONE;
        o_cmd.rd_go      = 1'b0;
        o_cmd.rd_purpose = RD_SCAN;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.op = OP_CAPTURE;
                end
            end
            ST_SCAN: begin
                if (i_stat.hit) begin
                    o_cmd.op = OP_MATCH;
                end else if (!i_stat.rd_done) begin
                    o_cmd.rd_go = 1'b1;
                end else if (!i_stat.scan_busy) begin
                    o_cmd.op = i_stat.full ? OP_DROP : OP_APPEND;
                end
            end
            ST_COUNT: begin
                o_cmd.rd_purpose = RD_COUNT;
                if (!i_stat.rd_done) begin
                    o_cmd.rd_go = 1'b1;
                end else if (!i_stat.rd_pending) begin
                    o_cmd.op = OP_REWIND;
                end
            end
            ST_MOVE: begin
                o_cmd.rd_purpose = RD_MOVE;
                if (!i_stat.rd_done) begin
                    o_cmd.rd_go = 1'b1;
                end else if (!i_stat.rd_pending) begin
                    o_cmd.op = OP_SUMMARY;
                end
            end
            default: begin
                o_cmd.op = OP_NONE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

// ===== rtl/tpt_datapath.sv =====
// ============================================================================
// Touch point tracker datapath
// Track table memory, distance pipeline, compaction pointers and result word.
// ============================================================================
module tpt_datapath #(
    parameter int MAX_TRACKS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tpt_pkg::t_dp_cmd  i_cmd,
    output tpt_pkg::t_dp_stat o_stat,
    input  logic              i_cfg_we,
    input  logic [9:0]        i_cfg_data,
    input  logic [15:0]       i_x_pos,
    input  logic [15:0]       i_y_pos,
    output logic              o_valid,
    output logic [2:0]        o_result_kind,
    output logic [15:0]       o_track_ident,
    output logic [4:0]        o_track_total,
    output logic              o_last_of_run
);
    import tpt_pkg::*;

    localparam int IDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int CNT_W = $clog2(MAX_TRACKS + 1);

    // Configuration and captured detection.
    logic [9:0]        r_radius;
    logic [19:0]       r_lim;
    logic [15:0]       r_x;
    logic [15:0]       r_y;

    // Track table and its bookkeeping.
    t_entry            r_mem [MAX_TRACKS];
    logic [CNT_W-1:0]  r_live;
    logic [15:0]       r_last_id;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_w;

    // Read stage.
    logic [CNT_W-1:0]  r_rd_idx;
    logic              r_rd_vld;
    t_rd               r_rd_purpose;
    logic [IDX_W-1:0]  r_rd_tag;
    t_entry            r_rd_data;

    // Difference stage.
    logic              r_d_vld;
    logic [IDX_W-1:0]  r_d_tag;
    logic [15:0]       r_dx;
    logic [15:0]       r_dy;
    logic [15:0]       r_d_ident;
    logic [1:0]        r_d_misses;

    // Square stage.
    logic              r_s_vld;
    logic [IDX_W-1:0]  r_s_tag;
    logic [31:0]       r_sx2;
    logic [31:0]       r_sy2;
    logic [15:0]       r_s_ident;
    logic [1:0]        r_s_misses;

    // Result word.
    logic              r_out_vld;
    t_kind             r_kind;
    logic [15:0]       r_ident;
    logic [CNT_W-1:0]  r_total;
    logic              r_last;

    // Combinational values.
    logic [15:0]       n_dx;
    logic [15:0]       n_dy;
    logic [32:0]       w_sum;
    logic              w_hit;
    logic              w_scan_rd;
    logic              w_count;
    logic              w_move;
    logic              w_removable;
    logic              w_flush;
    logic [15:0]       n_new_id;
    t_entry            n_kept;
    logic              n_wr_en;
    logic [IDX_W-1:0]  n_wr_addr;
    t_entry            n_wr_data;
    logic              n_out_vld;
    t_kind             n_kind;
    logic [15:0]       n_ident;
    logic [CNT_W-1:0]  n_total;
    logic              n_last;

    // Match radius and its square, the square registered from the radius.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
            r_lim    <= LIMIT_RESET;
        end else begin
            if (i_cfg_we) begin
                r_radius <= i_cfg_data;
            end
            r_lim <= {10'd0, r_radius} * {10'd0, r_radius};
        end
    end

    // Detection position is held for the whole item.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_CAPTURE) begin
            r_x <= i_x_pos;
            r_y <= i_y_pos;
        end
    end

    // Decoded read-stage conditions.
    assign w_flush     = (i_cmd.op == OP_MATCH);
    assign w_scan_rd   = r_rd_vld && (r_rd_purpose == RD_SCAN);
    assign w_count     = r_rd_vld && (r_rd_purpose == RD_COUNT);
    assign w_move      = r_rd_vld && (r_rd_purpose == RD_MOVE);
    assign w_removable = !r_rd_data.found && (r_rd_data.misses > MISS_LIMIT);

    // Read index and valid flags of the distance pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
            r_rd_vld <= 1'b0;
            r_d_vld  <= 1'b0;
            r_s_vld  <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_go && !w_flush;
            r_d_vld  <= w_scan_rd && !w_flush;
            r_s_vld  <= r_d_vld && !w_flush;
            if (i_cmd.op == OP_CAPTURE || i_cmd.op == OP_REWIND) begin
                r_rd_idx <= '0;
            end else if (i_cmd.rd_go) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
        end
    end

    // Table read port, data registered.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_go) begin
            r_rd_data    <= r_mem[r_rd_idx[IDX_W-1:0]];
            r_rd_tag     <= r_rd_idx[IDX_W-1:0];
            r_rd_purpose <= i_cmd.rd_purpose;
        end
    end

    // Absolute coordinate differences.
    always_comb begin
        n_dx = (r_rd_data.x > r_x) ? (r_rd_data.x - r_x) : (r_x - r_rd_data.x);
        n_dy = (r_rd_data.y > r_y) ? (r_rd_data.y - r_y) : (r_y - r_rd_data.y);
    end

    // Difference and square stages.
    always_ff @(posedge i_clk) begin
        r_d_tag    <= r_rd_tag;
        r_dx       <= n_dx;
        r_dy       <= n_dy;
        r_d_ident  <= r_rd_data.ident;
        r_d_misses <= r_rd_data.misses;
        r_s_tag    <= r_d_tag;
        r_sx2      <= {16'd0, r_dx} * {16'd0, r_dx};
        r_sy2      <= {16'd0, r_dy} * {16'd0, r_dy};
        r_s_ident  <= r_d_ident;
        r_s_misses <= r_d_misses;
    end

    // Squared distance against the squared radius.
    assign w_sum = {1'b0, r_sx2} + {1'b0, r_sy2};
    assign w_hit = r_s_vld && (w_sum < {13'd0, r_lim});

    // Id of an appended track.
    assign n_new_id = (r_live == '0) ? 16'd1 : (r_last_id + 16'd1);

    // A surviving entry after ageing.
    always_comb begin
        n_kept        = r_rd_data;
        n_kept.found  = 1'b0;
        n_kept.misses = r_rd_data.found ? 2'd0 : (r_rd_data.misses + 2'd1);
    end

    // Table write port.
    always_comb begin
        n_wr_en   = 1'b0;
        n_wr_addr = r_w[IDX_W-1:0];
        n_wr_data = n_kept;
        if (i_cmd.op == OP_MATCH) begin
            n_wr_en   = 1'b1;
            n_wr_addr = r_s_tag;
            n_wr_data = '{x: r_x, y: r_y, ident: r_s_ident, found: 1'b1,
                          misses: r_s_misses};
        end else if (i_cmd.op == OP_APPEND) begin
            n_wr_en   = 1'b1;
            n_wr_addr = r_live[IDX_W-1:0];
            n_wr_data = '{x: r_x, y: r_y, ident: n_new_id, found: 1'b0,
                          misses: 2'd0};
        end else if (w_move && !w_removable) begin
            n_wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_wr_en) begin
            r_mem[n_wr_addr] <= n_wr_data;
        end
    end

    // Live count, removal count and compaction pointer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= '0;
            r_rem  <= '0;
            r_w    <= '0;
        end else begin
            if (i_cmd.op == OP_CAPTURE) begin
                r_rem <= '0;
                r_w   <= '0;
            end
            if (w_count && w_removable) begin
                r_rem <= r_rem + 1'b1;
            end
            if (w_move && !w_removable) begin
                r_w <= r_w + 1'b1;
            end
            if (i_cmd.op == OP_APPEND) begin
                r_live <= r_live + 1'b1;
            end else if (i_cmd.op == OP_SUMMARY) begin
                r_live <= r_w;
                r_rem  <= '0;
            end
        end
    end

    // The id of the last entry is tracked so that appending needs no read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_APPEND) begin
            r_last_id <= n_new_id;
        end else if (w_move && !w_removable) begin
            r_last_id <= r_rd_data.ident;
        end
    end

    // Result word selection.
    always_comb begin
        n_out_vld = 1'b0;
        n_kind    = KIND_MATCH;
        n_ident   = 16'd0;
        n_total   = r_live;
        n_last    = 1'b1;
        case (i_cmd.op)
            OP_MATCH: begin
                n_out_vld = 1'b1;
                n_ident   = r_s_ident;
            end
            OP_APPEND: begin
                n_out_vld = 1'b1;
                n_kind    = KIND_NEW;
                n_ident   = n_new_id;
                n_total   = r_live + 1'b1;
            end
            OP_DROP: begin
                n_out_vld = 1'b1;
                n_kind    = KIND_DROPPED;
            end
            OP_SUMMARY: begin
                n_out_vld = 1'b1;
                n_kind    = KIND_SUMMARY;
                n_total   = r_w;
            end
            default: begin
                if (w_move && w_removable) begin
                    n_out_vld = 1'b1;
                    n_kind    = KIND_REMOVED;
                    n_ident   = r_rd_data.ident;
                    n_total   = r_live - r_rem;
                    n_last    = 1'b0;
                end
            end
        endcase
    end

    // Result register: each word is shown for one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_ident <= n_ident;
        r_total <= n_total;
        r_last  <= n_last;
    end

    assign o_valid       = r_out_vld;
    assign o_result_kind = r_kind;
    assign o_track_ident = r_ident;
    assign o_track_total = 5'(r_total);
    assign o_last_of_run = r_last;

    // Status to the controller.
    assign o_stat.hit        = w_hit;
    assign o_stat.scan_busy  = w_scan_rd || r_d_vld || r_s_vld;
    assign o_stat.rd_pending = r_rd_vld;
    assign o_stat.rd_done    = (r_rd_idx >= r_live);
    assign o_stat.full       = (r_live >= CNT_W'(MAX_TRACKS));

    // The table never holds more than its capacity.
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= CNT_W'(MAX_TRACKS))
        else $error("live count beyond table capacity");

    // Removals counted in the first pass never exceed the live entries.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem <= r_live)
        else $error("removal count beyond live count");

    // Compaction writes never overtake the entry being read.
    a_compact_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move |-> (r_w <= CNT_W'(r_rd_tag)))
        else $error("compaction pointer ahead of read index");

    // A match always refers to a live entry.
    a_hit_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hit |-> (CNT_W'(r_s_tag) < r_live))
        else $error("match on an entry beyond the live count");

endmodule

// ===== rtl/touch_point_tracker_core.sv =====
// ============================================================================
// Touch point tracker core
// Associates touch detections with a compacted table of tracked points.
// ============================================================================
// A detection keeps busy high while the scan reads one table entry a cycle
// from the table memory into a three-stage distance pipeline (read,
// difference, square); the scan stops at the first match. An end-of-frame
// item keeps busy high while it makes two passes over the table memory,
// one read a cycle: one to count the removals and one to compact the
// table. Each result word is shown on the result ports for exactly one
// cycle with o_valid high and must be taken then; the word of a detection
// and the frame summary appear in the first cycle in which busy is low,
// and the removal words of an end-of-frame item appear in table order
// during the second pass, ahead of the summary. start is taken while busy
// is low, which may be in the same cycle as the last result word of the
// previous item.
module touch_point_tracker_core #(
    parameter int MAX_TRACKS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_command,
    input  logic [15:0] i_x_pos,
    input  logic [15:0] i_y_pos,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [9:0]  i_cfg_data,
    output logic        o_valid,
    output logic [2:0]  o_result_kind,
    output logic [15:0] o_track_ident,
    output logic [4:0]  o_track_total,
    output logic        o_last_of_run
);
    import tpt_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_busy;
    logic     w_cfg_we;

    // Configuration is taken whenever no item is in progress.
    assign o_cfg_ready = !w_busy;
    assign w_cfg_we    = i_cfg_valid && !w_busy;
    assign busy        = w_busy;

    tpt_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_command),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd),
        .o_busy    (w_busy)
    );

    tpt_datapath #(
        .MAX_TRACKS (MAX_TRACKS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_cfg_we      (w_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_x_pos       (i_x_pos),
        .i_y_pos       (i_y_pos),
        .o_valid       (o_valid),
        .o_result_kind (o_result_kind),
        .o_track_ident (o_track_ident),
        .o_track_total (o_track_total),
        .o_last_of_run (o_last_of_run)
    );

endmodule
